@@ design/ctsq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctsq_pkg
// Types, codes and constants shared by the comparator trim search sequencer.
// ----------------------------------------------------------------------------
package ctsq_pkg;

  localparam int unsigned CfgCount = 8;
  localparam int unsigned CfgIndexWidth = $clog2(CfgCount);

  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_DAC_A    = 4'd1,
    PH_DAC_B    = 4'd2,
    PH_MEM_0    = 4'd3,
    PH_MEM_1    = 4'd4,
    PH_MEM_2    = 4'd5,
    PH_MEM_3    = 4'd6,
    PH_VSEL     = 4'd7,
    PH_DEFAULT  = 4'd8,
    PH_SENSE0   = 4'd9,
    PH_STEP     = 4'd10,
    PH_SENSE    = 4'd11,
    PH_READBACK = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_PASS = 2'd2,
    ST_FAIL = 2'd3
  } run_status_t;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_DAC  = 3'd1,
    K_MEMW = 3'd2,
    K_MEMR = 3'd3,
    K_PHYW = 3'd4,
    K_PHYR = 3'd5
  } req_kind_t;

  typedef enum logic [1:0] {
    RT_FIRST  = 2'd0,
    RT_LOWER  = 2'd1,
    RT_HIGHER = 2'd2
  } retest_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_VOLTAGE_SELECT     = 3'd0,
    CFG_TRIM_PHY_ADDRESS   = 3'd1,
    CFG_DEFAULT_TRIM_WORD  = 3'd2,
    CFG_RESULT_BIT_INDEX   = 3'd3,
    CFG_TRIM_NIBBLE_SELECT = 3'd4,
    CFG_DAC_START_WORD     = 3'd5,
    CFG_DAC_LOWER_WORD     = 3'd6,
    CFG_DAC_HIGHER_WORD    = 3'd7
  } cfg_index_t;

  localparam logic CMD_START = 1'b0;

  localparam logic [15:0] ADDR_MEM_0 = 16'hdf08;
  localparam logic [15:0] ADDR_MEM_1 = 16'hc1a2;
  localparam logic [15:0] ADDR_MEM_2 = 16'hc1a3;
  localparam logic [15:0] ADDR_MEM_3 = 16'hc1ae;
  localparam logic [15:0] ADDR_VSEL  = 16'hc1a0;
  localparam logic [15:0] ADDR_SENSE = 16'hc1a9;
  localparam logic [15:0] DATA_ZERO  = 16'h0000;
  localparam logic [15:0] DATA_SIX   = 16'h0006;

  localparam logic [3:0] UP_LIMIT   = 4'd7;
  localparam logic [3:0] DOWN_LIMIT = 4'd8;

  typedef struct packed {
    logic [7:0]  voltage_select;
    logic [15:0] trim_phy_address;
    logic [15:0] default_trim_word;
    logic [2:0]  result_bit_index;
    logic [1:0]  trim_nibble_select;
    logic [15:0] dac_start_word;
    logic [15:0] dac_lower_word;
    logic [15:0] dac_higher_word;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    run_status_t status;
    logic        down;
    logic [3:0]  offset;
    retest_t     retest;
    logic [15:0] dac_word;
    logic [15:0] result_word;
  } seq_state_t;

  typedef struct packed {
    req_kind_t   req_kind;
    logic [15:0] req_address;
    logic [15:0] req_write_data;
    run_status_t run_status;
    retest_t     retest_mode;
    logic [15:0] trim_result;
    logic [3:0]  current_offset;
    logic        search_down;
  } result_t;

endpackage
`default_nettype wire

@@ design/ctsq_item_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctsq_item_if
// Command and response channel into the sequencer.
// ----------------------------------------------------------------------------
interface ctsq_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        resp_pass;
  logic [15:0] resp_data;

  modport source (output valid, output cmd, output resp_pass, output resp_data, input ready);
  modport sink (input valid, input cmd, input resp_pass, input resp_data, output ready);
endinterface
`default_nettype wire

@@ design/ctsq_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctsq_result_if
// Request and status channel out of the sequencer.
// ----------------------------------------------------------------------------
interface ctsq_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_kind;
  logic [15:0] req_address;
  logic [15:0] req_write_data;
  logic [1:0]  run_status;
  logic [1:0]  retest_mode;
  logic [15:0] trim_result;
  logic [3:0]  current_offset;
  logic        search_down;

  modport source (
    output valid, output req_kind, output req_address, output req_write_data,
    output run_status, output retest_mode, output trim_result,
    output current_offset, output search_down, input ready
  );
  modport sink (
    input valid, input req_kind, input req_address, input req_write_data,
    input run_status, input retest_mode, input trim_result,
    input current_offset, input search_down, output ready
  );
endinterface
`default_nettype wire

@@ design/ctsq_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctsq_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface ctsq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/ctsq_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctsq_step
// Next-state and request formation for one command or response.
// ----------------------------------------------------------------------------
module ctsq_step (
  input  wire ctsq_pkg::seq_state_t st,
  input  wire ctsq_pkg::cfg_t       cfg,
  input  wire logic                 cmd,
  input  wire logic                 resp_pass,
  input  wire logic [15:0]          resp_data,
  output ctsq_pkg::seq_state_t      st_next,
  output ctsq_pkg::result_t         res
);
  import ctsq_pkg::*;

  logic        emit_wait;
  logic        sense_bit;
  phase_t      emit_phase;
  logic [7:0]  delta;
  logic [7:0]  byte_now;
  logic [7:0]  byte_new;
  logic [15:0] stepped;

  assign sense_bit = resp_data[{1'b0, cfg.result_bit_index}];

  always_comb begin
    st_next   = st;
    emit_wait = 1'b0;
    if (cmd == CMD_START) begin
      if (st.status != ST_RUN) begin
        st_next.status   = ST_RUN;
        st_next.retest   = RT_FIRST;
        st_next.dac_word = cfg.dac_start_word;
        st_next.phase    = PH_DAC_A;
      end else begin
        emit_wait = 1'b1;
      end
    end else if (st.phase == PH_WAIT || st.status != ST_RUN) begin
      emit_wait = 1'b1;
    end else if (st.phase == PH_DAC_A) begin
      st_next.phase = PH_DAC_B;
    end else if (st.phase == PH_DAC_B) begin
      st_next.phase = PH_MEM_0;
    end else if (resp_pass) begin
      case (st.phase)
        PH_MEM_0: st_next.phase = PH_MEM_1;
        PH_MEM_1: st_next.phase = PH_MEM_2;
        PH_MEM_2: st_next.phase = PH_MEM_3;
        PH_MEM_3: st_next.phase = PH_VSEL;
        PH_VSEL: begin
          st_next.phase  = PH_DEFAULT;
          st_next.down   = 1'b0;
          st_next.offset = 4'd0;
        end
        PH_DEFAULT: st_next.phase = PH_SENSE0;
        PH_SENSE0: begin
          st_next.down   = ~sense_bit;
          st_next.offset = 4'd1;
          st_next.phase  = PH_STEP;
        end
        PH_STEP: st_next.phase = PH_SENSE;
        PH_SENSE: begin
          if (sense_bit == st.down) begin
            st_next.phase = PH_READBACK;
          end else if (st.offset < (st.down ? DOWN_LIMIT : UP_LIMIT)) begin
            st_next.offset = st.offset + 4'd1;
            st_next.phase  = PH_STEP;
          end else if (st.retest == RT_FIRST) begin
            st_next.retest   = st.down ? RT_HIGHER : RT_LOWER;
            st_next.dac_word = st.down ? cfg.dac_higher_word : cfg.dac_lower_word;
            st_next.phase    = PH_DAC_B;
          end else begin
            st_next.phase  = PH_WAIT;
            st_next.status = ST_FAIL;
          end
        end
        PH_READBACK: begin
          st_next.result_word = resp_data;
          st_next.status      = ST_PASS;
          st_next.phase       = PH_WAIT;
        end
        default: st_next.phase = PH_WAIT;
      endcase
    end
  end

  // step the selected nibble within its byte, modulo 256
  always_comb begin
    delta    = cfg.trim_nibble_select[0] ? {st_next.offset, 4'd0} : {4'd0, st_next.offset};
    byte_now = cfg.trim_nibble_select[1] ? cfg.default_trim_word[15:8]
                                         : cfg.default_trim_word[7:0];
    byte_new = st_next.down ? byte_now - delta : byte_now + delta;
    stepped  = cfg.trim_nibble_select[1] ? {byte_new, cfg.default_trim_word[7:0]}
                                         : {cfg.default_trim_word[15:8], byte_new};
  end

  assign emit_phase = emit_wait ? PH_WAIT : st_next.phase;

  always_comb begin
    res.req_kind       = K_NONE;
    res.req_address    = DATA_ZERO;
    res.req_write_data = DATA_ZERO;
    case (emit_phase)
      PH_DAC_A, PH_DAC_B: begin
        res.req_kind       = K_DAC;
        res.req_write_data = st_next.dac_word;
      end
      PH_MEM_0: begin
        res.req_kind    = K_MEMW;
        res.req_address = ADDR_MEM_0;
      end
      PH_MEM_1: begin
        res.req_kind       = K_MEMW;
        res.req_address    = ADDR_MEM_1;
        res.req_write_data = DATA_SIX;
      end
      PH_MEM_2: begin
        res.req_kind       = K_MEMW;
        res.req_address    = ADDR_MEM_2;
        res.req_write_data = DATA_SIX;
      end
      PH_MEM_3: begin
        res.req_kind    = K_MEMW;
        res.req_address = ADDR_MEM_3;
      end
      PH_VSEL: begin
        res.req_kind       = K_MEMW;
        res.req_address    = ADDR_VSEL;
        res.req_write_data = {8'd0, cfg.voltage_select};
      end
      PH_DEFAULT: begin
        res.req_kind       = K_PHYW;
        res.req_address    = cfg.trim_phy_address;
        res.req_write_data = cfg.default_trim_word;
      end
      PH_SENSE0, PH_SENSE: begin
        res.req_kind    = K_MEMR;
        res.req_address = ADDR_SENSE;
      end
      PH_STEP: begin
        res.req_kind       = K_PHYW;
        res.req_address    = cfg.trim_phy_address;
        res.req_write_data = stepped;
      end
      PH_READBACK: begin
        res.req_kind    = K_PHYR;
        res.req_address = cfg.trim_phy_address;
      end
      default: res.req_kind = K_NONE;
    endcase
    res.run_status     = st_next.status;
    res.retest_mode    = st_next.retest;
    res.trim_result    = st_next.result_word;
    res.current_offset = st_next.offset;
    res.search_down    = st_next.down;
  end

endmodule
`default_nettype wire

@@ design/comparator_trim_search_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// comparator_trim_search_sequencer
// Auto-trim sequencer that drives a comparator trim search over a bus.
// ----------------------------------------------------------------------------
// Each accepted command or response produces exactly one registered result
// in the cycle after it: the next bus request (kind none when nothing is to
// be issued) with the run status, retest mode, search offset, direction and
// trim readback. A new item can be taken every cycle unless a held result
// is not being taken; the state update and request formation sit between
// the sequencer state registers and the result register, and the input stays
// ready while a held result is being taken. Configuration registers reset to
// zero and are written through the cfg channel, which is always ready.
module comparator_trim_search_sequencer (
  input  wire logic    clk,
  input  wire logic    rst,
  ctsq_item_if.sink    item,
  ctsq_result_if.source result,
  ctsq_cfg_if.sink     cfg
);
  import ctsq_pkg::*;

  cfg_t       regs;
  seq_state_t st;
  seq_state_t st_next;
  result_t    res_next;
  result_t    res;
  logic       res_valid;
  logic       accept;

  assign cfg.ready  = 1'b1;
  assign item.ready = ~res_valid | result.ready;
  assign accept     = item.valid & item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_VOLTAGE_SELECT:     regs.voltage_select     <= cfg.data[7:0];
        CFG_TRIM_PHY_ADDRESS:   regs.trim_phy_address   <= cfg.data;
        CFG_DEFAULT_TRIM_WORD:  regs.default_trim_word  <= cfg.data;
        CFG_RESULT_BIT_INDEX:   regs.result_bit_index   <= cfg.data[2:0];
        CFG_TRIM_NIBBLE_SELECT: regs.trim_nibble_select <= cfg.data[1:0];
        CFG_DAC_START_WORD:     regs.dac_start_word     <= cfg.data;
        CFG_DAC_LOWER_WORD:     regs.dac_lower_word     <= cfg.data;
        CFG_DAC_HIGHER_WORD:    regs.dac_higher_word    <= cfg.data;
        default:                regs <= regs;
      endcase
    end
  end

  ctsq_step u_step (
    .st        (st),
    .cfg       (regs),
    .cmd       (item.cmd),
    .resp_pass (item.resp_pass),
    .resp_data (item.resp_data),
    .st_next   (st_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_WAIT;
      st.status      <= ST_IDLE;
      st.down        <= 1'b0;
      st.offset      <= 4'd0;
      st.retest      <= RT_FIRST;
      st.dac_word    <= 16'd0;
      st.result_word <= 16'd0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // hold the payload until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.req_kind       = res.req_kind;
  assign result.req_address    = res.req_address;
  assign result.req_write_data = res.req_write_data;
  assign result.run_status     = res.run_status;
  assign result.retest_mode    = res.retest_mode;
  assign result.trim_result    = res.trim_result;
  assign result.current_offset = res.current_offset;
  assign result.search_down    = res.search_down;

endmodule
`default_nettype wire
